### design/npcs_pkg.sv
// npcs_pkg: constants, mode codes and the colour distance function
// for the nearest palette colour search unit; no dependencies
package npcs_pkg;

  // palette geometry
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_IDX_W   = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam int PAL_CNT_W   = $clog2(PAL_ENTRIES + 1);

  // item field widths
  localparam int COMP_W  = 8;
  localparam int INDEX_W = 8;
  localparam int WORD_W  = 3 * COMP_W;

  // squared distance: three squares of COMP_W-bit differences
  localparam int SQ_W   = 2 * COMP_W;
  localparam int DIST_W = SQ_W + 2;

  // running minimum start value, above any real distance (max 3*255*255)
  localparam logic [DIST_W-1:0] DIST_START = '1;

  // mode codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [DIST_W-1:0] dist_t;

  // squared absolute difference of two components
  function automatic logic [SQ_W-1:0] comp_sq(input comp_t a, input comp_t b);
    comp_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  // squared euclidean distance of a stored word to a query colour
  function automatic dist_t rgb_dist(input logic [WORD_W-1:0] w,
                                     input comp_t r, input comp_t g, input comp_t b);
    return DIST_W'(comp_sq(w[3*COMP_W-1:2*COMP_W], r))
         + DIST_W'(comp_sq(w[2*COMP_W-1:COMP_W], g))
         + DIST_W'(comp_sq(w[COMP_W-1:0], b));
  endfunction

endpackage

### design/nearest_palette_color_search_unit.sv
// nearest_palette_color_search_unit: palette store and sequential
// nearest colour scanner; depends on npcs_pkg
//
// The block holds a palette of PAL_ENTRIES RGB colours in a single-port
// read / single-port write memory. A write item (mode 0) stores one colour;
// indexes at or above PAL_ENTRIES are dropped. A query item (mode 1) starts
// a scan that reads one palette entry per cycle through the memory read
// port and feeds it to one distance unit (three small squares and an add)
// with a compare against the running minimum. A scan ends after the last
// entry is compared, or early on an exact match. in_ready is low while a
// scan runs or a result is held. Ties go to the lowest index. The palette
// has no reset: every entry must be written before a query scans it. The
// result sits in an output register, so a new item may be taken while the
// last result is still waiting.
module nearest_palette_color_search_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [npcs_pkg::INDEX_W-1:0] in_entry_index,
  input  logic [npcs_pkg::COMP_W-1:0]  in_red,
  input  logic [npcs_pkg::COMP_W-1:0]  in_green,
  input  logic [npcs_pkg::COMP_W-1:0]  in_blue,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [npcs_pkg::INDEX_W-1:0] out_best_index
);
  import npcs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_t;

  localparam logic [PAL_CNT_W-1:0] ENTRIES_CNT = PAL_CNT_W'(PAL_ENTRIES);

  // palette memory
  logic [WORD_W-1:0] pal_mem [PAL_ENTRIES];

  state_t                 state_r, state_nxt;
  logic [PAL_CNT_W-1:0]   issue_r, issue_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [PAL_IDX_W-1:0]   rd_idx_r;
  logic [WORD_W-1:0]      rd_data_r;
  comp_t                  q_red_r, q_green_r, q_blue_r;
  dist_t                  best_dist_r, best_dist_nxt;
  logic [PAL_IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [PAL_IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]     out_idx_r, out_idx_nxt;

  logic                   in_acc;
  logic                   wr_en;
  logic [PAL_IDX_W-1:0]   wr_addr;
  logic                   rd_en;
  logic [PAL_IDX_W-1:0]   rd_addr;
  dist_t                  cand_dist;
  logic                   better;
  logic                   hit;
  logic                   scan_done;
  logic [PAL_IDX_W-1:0]   final_idx;
  logic                   out_free;

  assign in_ready       = (state_r == ST_IDLE);
  assign in_acc         = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_best_index = out_idx_r;
  assign out_free       = !out_valid_r || out_ready;

  // write path: drop indexes beyond the palette
  assign wr_en   = in_acc && (in_mode == MODE_WRITE) && (32'(in_entry_index) < PAL_ENTRIES);
  assign wr_addr = PAL_IDX_W'(in_entry_index);

  // read issue: one entry per cycle while scanning
  assign rd_addr = issue_r[PAL_IDX_W-1:0];
  assign rd_en   = (state_r == ST_SCAN) && (issue_r < ENTRIES_CNT);

  // shared distance unit and compare
  assign cand_dist = rgb_dist(rd_data_r, q_red_r, q_green_r, q_blue_r);
  assign better    = rd_vld_r && (cand_dist < best_dist_r);
  assign hit       = better && (cand_dist == '0);
  assign scan_done = hit || (!rd_vld_r && (issue_r == ENTRIES_CNT));
  assign final_idx = better ? rd_idx_r : best_idx_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[wr_addr] <= {in_red, in_green, in_blue};
    end
    if (rd_en) begin
      rd_data_r <= pal_mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    rd_vld_nxt    = rd_en;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    if (rd_en) begin
      issue_nxt = issue_r + 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_mode == MODE_QUERY)) begin
          state_nxt     = ST_SCAN;
          issue_nxt     = '0;
          best_dist_nxt = DIST_START;
          best_idx_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (better) begin
          best_dist_nxt = cand_dist;
          best_idx_nxt  = rd_idx_r;
        end
        if (scan_done) begin
          rd_vld_nxt  = 1'b0;
          res_idx_nxt = final_idx;
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = INDEX_W'(final_idx);
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = INDEX_W'(res_idx_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      issue_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      issue_r     <= issue_nxt;
    end
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    res_idx_r   <= res_idx_nxt;
    out_idx_r   <= out_idx_nxt;
    if (in_acc && (in_mode == MODE_QUERY)) begin
      q_red_r   <= in_red;
      q_green_r <= in_green;
      q_blue_r  <= in_blue;
    end
  end

  // scan counter never runs past the palette
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r <= ENTRIES_CNT)
    else $error("scan counter past palette end");

  // an entry under compare was issued earlier in this scan
  a_rd_order: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r && state_r == ST_SCAN) |-> ({1'b0, rd_idx_r} < issue_r))
    else $error("compared entry not yet issued");

  // a new result only comes out of a scan or a held result
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_ready)) |->
      ($past(state_r == ST_SCAN) || $past(state_r == ST_HOLD)))
    else $error("result without a scan");

  // holding a result means the output register is still occupied
  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("hold state with free output");

  // no read is pending once the block is idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !rd_vld_r)
    else $error("read in flight while idle");

endmodule

### tb/sv/nearest_palette_color_search_unit_test.sv
// testbench for nearest_palette_color_search_unit: palette fill, directed and
// random write / query items, checked against an in-bench nearest colour board
// depends on npcs_pkg and the unit under test
`timescale 1ns / 100ps

module nearest_palette_color_search_unit_test;
  import npcs_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1080;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 2 * PAL_ENTRIES + 40;
  localparam int SENDER_SIDE  = 0;
  localparam int RECEIVER_SIDE = 1;

  // shadow palette and expected best indexes, in order of queries taken
  class nearest_colour_board;
    logic [WORD_W-1:0]  palette [PAL_ENTRIES];
    logic [INDEX_W-1:0] pending_best [$];
    int                 mismatch_count;

    function new();
      mismatch_count = 0;
      foreach (palette[i]) palette[i] = '0;
    endfunction

    function int unsigned sq_diff(logic [COMP_W-1:0] a, logic [COMP_W-1:0] c);
      int unsigned d;
      d = (a >= c) ? (a - c) : (c - a);
      return d * d;
    endfunction

    // lowest index at least squared distance, scan stops on an exact match
    function logic [INDEX_W-1:0] closest_entry(logic [COMP_W-1:0] r,
                                               logic [COMP_W-1:0] g,
                                               logic [COMP_W-1:0] b);
      int unsigned best_dist;
      int unsigned d;
      int          best;
      best_dist = 32'h7fff_ffff;
      best = 0;
      for (int i = 0; i < PAL_ENTRIES; i++) begin
        d = sq_diff(palette[i][23:16], r) + sq_diff(palette[i][15:8], g)
          + sq_diff(palette[i][7:0], b);
        if (d < best_dist) begin
          best_dist = d;
          best = i;
          if (d == 0) break;
        end
      end
      return best[INDEX_W-1:0];
    endfunction

    // an accepted input item: writes update the palette, queries queue an answer
    function void take_item(logic mode, logic [INDEX_W-1:0] idx, logic [COMP_W-1:0] r,
                            logic [COMP_W-1:0] g, logic [COMP_W-1:0] b);
      if (mode == MODE_WRITE) begin
        if (idx < PAL_ENTRIES) palette[idx] = {r, g, b};
      end else begin
        pending_best.push_back(closest_entry(r, g, b));
      end
    endfunction

    function void check_index(logic [INDEX_W-1:0] got);
      logic [INDEX_W-1:0] want;
      if (pending_best.size() == 0) begin
        $display("%0t: unexpected result item, best_index %0d", $time, got);
        mismatch_count++;
      end else begin
        want = pending_best.pop_front();
        if (got !== want) begin
          $display("%0t: best_index mismatch, expected %0d actual %0d", $time, want, got);
          mismatch_count++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_mode = MODE_WRITE;
  logic [INDEX_W-1:0] in_entry_index = '0;
  logic [COMP_W-1:0]  in_red = '0;
  logic [COMP_W-1:0]  in_green = '0;
  logic [COMP_W-1:0]  in_blue = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [INDEX_W-1:0] out_best_index;

  nearest_colour_board board;
  int                  calm_left [2];
  int                  cycle_count = 0;
  int                  results_taken = 0;

  nearest_palette_color_search_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_index (out_best_index)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("%0t: run limit reached", $time);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // idle cycles before the next item, with calm stretches of no idling
  function int draw_gap(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left[side] = $urandom_range(10, 40);
    return $urandom_range(0, 19);
  endfunction

  // small random shift of a component, kept in range
  function logic [COMP_W-1:0] nudge(logic [COMP_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[COMP_W-1:0];
  endfunction

  // offer one item after a random gap and hold it until taken
  task automatic send_item(logic mode, logic [INDEX_W-1:0] idx, logic [COMP_W-1:0] r,
                           logic [COMP_W-1:0] g, logic [COMP_W-1:0] b);
    int gap;
    gap = draw_gap(SENDER_SIDE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode        <= mode;
    in_entry_index <= idx;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    board.take_item(mode, idx, r, g, b);
    @(negedge clk);
  endtask

  // result side: random stalls, two long hold-offs to back the block up
  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap(RECEIVER_SIDE);
      if (results_taken == 15 || results_taken == 260) gap = LONG_HOLD;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      board.check_index(out_best_index);
      results_taken++;
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int                 pick;
    int                 k;
    logic [INDEX_W-1:0] ix;
    logic [WORD_W-1:0]  w;
    board = new();
    calm_left[SENDER_SIDE] = 0;
    calm_left[RECEIVER_SIDE] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill every entry before any query; black at 0, white at the top,
    // one colour twice for ties
    for (k = 0; k < PAL_ENTRIES; k++) begin
      if (k == 0) w = 24'h000000;
      else if (k == PAL_ENTRIES - 1) w = 24'hffffff;
      else if (k == 100 || k == 200) w = 24'h102030;
      else w = WORD_W'($urandom());
      send_item(MODE_WRITE, k[INDEX_W-1:0], w[23:16], w[15:8], w[7:0]);
    end

    // directed: exact match at the first entry, at the last, ties and extremes
    send_item(MODE_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(MODE_QUERY, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(MODE_QUERY, 8'h5a, 8'h10, 8'h20, 8'h30);
    send_item(MODE_QUERY, 8'ha5, 8'h10, 8'h20, 8'h31);
    send_item(MODE_QUERY, 8'h00, 8'hff, 8'h00, 8'h00);
    send_item(MODE_QUERY, 8'h00, 8'h00, 8'hff, 8'h00);
    send_item(MODE_QUERY, 8'h00, 8'h00, 8'h00, 8'hff);
    send_item(MODE_QUERY, 8'h00, 8'h80, 8'h80, 8'h80);
    send_item(MODE_QUERY, 8'h00, 8'h7f, 8'h7f, 8'h7f);
    // move white down to entry 1 so the top entry loses the tie
    send_item(MODE_WRITE, 8'h01, 8'hff, 8'hff, 8'hff);
    send_item(MODE_QUERY, 8'h00, 8'hff, 8'hff, 8'hff);
    send_item(MODE_QUERY, 8'h00, 8'hfe, 8'hff, 8'hff);
    // black at the top entry too: entry 0 still wins
    send_item(MODE_WRITE, 8'hff, 8'h00, 8'h00, 8'h00);
    send_item(MODE_QUERY, 8'h00, 8'h01, 8'h00, 8'h00);
    // exact match only at the very last entry
    send_item(MODE_WRITE, 8'hff, 8'h55, 8'haa, 8'h55);
    send_item(MODE_QUERY, 8'hff, 8'h55, 8'haa, 8'h55);
    send_item(MODE_WRITE, 8'h00, 8'hff, 8'h00, 8'hff);
    send_item(MODE_QUERY, 8'h00, 8'hff, 8'h00, 8'hff);
    send_item(MODE_QUERY, 8'h00, 8'h00, 8'hff, 8'h00);

    // random: writes with fresh, copied or nudged colours; exact, near and
    // arbitrary queries
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      ix = INDEX_W'($urandom());
      w = board.palette[$urandom_range(0, PAL_ENTRIES - 1)];
      if (pick < 45) begin
        if (pick < 10) send_item(MODE_WRITE, ix, w[23:16], w[15:8], w[7:0]);
        else if (pick < 20)
          send_item(MODE_WRITE, ix, nudge(w[23:16]), nudge(w[15:8]), nudge(w[7:0]));
        else send_item(MODE_WRITE, ix, COMP_W'($urandom()), COMP_W'($urandom()),
                       COMP_W'($urandom()));
      end else if (pick < 63) begin
        send_item(MODE_QUERY, ix, w[23:16], w[15:8], w[7:0]);
      end else if (pick < 81) begin
        send_item(MODE_QUERY, ix, nudge(w[23:16]), nudge(w[15:8]), nudge(w[7:0]));
      end else if (pick < 85) begin
        w = {$urandom_range(0, 1) ? 8'hff : 8'h00, $urandom_range(0, 1) ? 8'hff : 8'h00,
             $urandom_range(0, 1) ? 8'hff : 8'h00};
        send_item(MODE_QUERY, ix, w[23:16], w[15:8], w[7:0]);
      end else begin
        send_item(MODE_QUERY, ix, COMP_W'($urandom()), COMP_W'($urandom()),
                  COMP_W'($urandom()));
      end
    end
    in_valid <= 1'b0;

    // drain, then wait DRAIN_CYCLES more for stray results
    while (board.pending_best.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending_best.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
